// File: design/acvc_pkg.sv
// Shared types, widths and constants of the converter conditioner.
// No dependencies; imported by the lane and the top level.
package acvc_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int REQ_DATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W  = 64;

   localparam int OPND_W = SAMPLE_BITS + 1;
   localparam int X_W    = OPND_W + 17;
   localparam int D_W    = 33;
   localparam int P_W    = D_W + 18;
   localparam int DL_W   = P_W - 16;
   localparam int SUM_W  = DL_W + 1;

   localparam logic [SAMPLE_BITS-1:0] CURRENT_OFFSET_RST = SAMPLE_BITS'(2048);
   localparam logic [15:0] CURRENT_SCALE_RST = 16'd264;
   localparam logic [15:0] VOLTAGE_SCALE_RST = 16'd484;
   localparam logic [16:0] ALPHA_ONE         = 17'h10000;

   typedef enum logic [1:0] {
      CSR_CURRENT_OFFSET = 2'd0,
      CSR_CURRENT_SCALE  = 2'd1,
      CSR_VOLTAGE_SCALE  = 2'd2,
      CSR_FILTER_ALPHA   = 2'd3
   } csr_addr_type;

   typedef enum logic {
      KIND_PHASE = 1'b0,
      KIND_BUS   = 1'b1
   } kind_type;

   typedef struct packed {
      logic scale_en;
      logic filt_en;
      logic round_en;
      logic bypass;
   } lane_ctrl_type;

   function automatic logic signed [31:0] acvc_sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(32'sh7FFF_FFFF);
      lo = SUM_W'(32'sh8000_0000);
      if (v > hi) begin
         return hi[31:0];
      end else if (v < lo) begin
         return lo[31:0];
      end
      return v[31:0];
   endfunction

endpackage

// File: design/adc_current_voltage_conditioner_unit.sv
// Conditioner for pairs of converter samples: offset, scale and first-order low-pass.
// Each sample pair passes capture, scale multiply, filter multiply, then round and
// state update, with the result going to the output register in the round step, which
// waits until the output register is free; one pair is in the lanes at a time, and a
// new pair is taken while a finished result waits on rsp. Bus pairs skip the filter.
// Depends on acvc_pkg and acvc_lane.
module adc_current_voltage_conditioner_unit import acvc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample_first, sample_second
   input  logic                  req_tuser,   // op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // value_first, value_second
   output logic                  rsp_tuser,   // kind
   input  logic                  csr_we,
   input  logic [1:0]            csr_addr,
   input  logic [16:0]           csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCALE = 4'b0010,
      ST_FILT  = 4'b0100,
      ST_ROUND = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic                    op_ff;
   logic [SAMPLE_BITS-1:0]  s1_ff, s2_ff;
   logic [SAMPLE_BITS-1:0]  offset_ff;
   logic [15:0]             cscale_ff, vscale_ff;
   logic [16:0]             alpha_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_kind_ff;
   logic signed [31:0]      rsp_v1_ff, rsp_v2_ff;
   logic                    req_fire;
   logic                    out_free;
   logic [16:0]             alpha_eff;
   logic signed [OPND_W-1:0] diff1, diff2, opnd2;
   logic [15:0]             scale2;
   lane_ctrl_type           ctrl;
   logic signed [31:0]      val1, val2;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign alpha_eff  = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;

   assign diff1  = $signed({1'b0, s1_ff}) - $signed({1'b0, offset_ff});
   assign diff2  = $signed({1'b0, s2_ff}) - $signed({1'b0, offset_ff});
   assign opnd2  = (op_ff == KIND_BUS) ? $signed({1'b0, s2_ff}) : diff2;
   assign scale2 = (op_ff == KIND_BUS) ? vscale_ff : cscale_ff;

   always_comb begin
      ctrl.scale_en = (state_ff == ST_SCALE);
      ctrl.filt_en  = (state_ff == ST_FILT);
      ctrl.round_en = (state_ff == ST_ROUND) && out_free;
      ctrl.bypass   = (op_ff == KIND_BUS);
   end

   acvc_lane u_lane_first (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .operand (diff1),
      .scale   (cscale_ff),
      .alpha   (alpha_eff),
      .value   (val1)
   );

   acvc_lane u_lane_second (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .operand (opnd2),
      .scale   (scale2),
      .alpha   (alpha_eff),
      .value   (val2)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: state_in = ST_FILT;
         ST_FILT:  state_in = ST_ROUND;
         ST_ROUND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff <= req_tuser;
         s1_ff <= req_tdata[SAMPLE_BITS-1:0];
         s2_ff <= req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= CURRENT_OFFSET_RST;
         cscale_ff <= CURRENT_SCALE_RST;
         vscale_ff <= VOLTAGE_SCALE_RST;
         alpha_ff  <= ALPHA_ONE;
      end else if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_CURRENT_OFFSET: offset_ff <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_CURRENT_SCALE:  cscale_ff <= csr_wdata[15:0];
            CSR_VOLTAGE_SCALE:  vscale_ff <= csr_wdata[15:0];
            CSR_FILTER_ALPHA:   alpha_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // merge: both lanes land in the output register together
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.round_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.round_en) begin
         rsp_kind_ff <= op_ff;
         rsp_v1_ff   <= val1;
         rsp_v2_ff   <= val2;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {rsp_v2_ff, rsp_v1_ff};

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> ##1 (state_ff == ST_FILT))
      else $error("sample pair did not advance through the lanes");
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      ctrl.round_en |=> rsp_valid_ff && (rsp_kind_ff == $past(op_ff)))
      else $error("result beat not loaded");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) && rsp_valid_ff && !rsp_tready |=> (state_ff == ST_ROUND))
      else $error("waiting result overwritten");
`endif

endmodule

// File: design/acvc_lane.sv
// One conditioning lane: scale multiply, low-pass multiply, round and state update.
// Depends on acvc_pkg. Bus beats bypass the filter and keep its state.
module acvc_lane import acvc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  lane_ctrl_type            ctrl,
   input  logic signed [OPND_W-1:0] operand,
   input  logic [15:0]              scale,
   input  logic [16:0]              alpha,
   output logic signed [31:0]       value
);

   logic signed [X_W-1:0]   prod;
   logic signed [31:0]      x_ff, x_in;
   logic signed [D_W-1:0]   diff;
   logic signed [P_W-1:0]   p_ff, p_in;
   logic signed [P_W-1:0]   rnd;
   logic signed [DL_W-1:0]  delta;
   logic signed [SUM_W-1:0] sum;
   logic signed [31:0]      y_ff, y_in;

   assign prod  = operand * $signed({1'b0, scale});
   assign x_in  = acvc_sat32(SUM_W'(prod));
   assign diff  = D_W'(x_ff) - D_W'(y_ff);
   assign p_in  = diff * $signed({1'b0, alpha});
   assign rnd   = p_ff + $signed(P_W'(32768));
   assign delta = DL_W'(rnd >>> 16);
   assign sum   = SUM_W'(y_ff) + SUM_W'(delta);
   assign y_in  = acvc_sat32(sum);
   assign value = ctrl.bypass ? x_ff : y_in;

   always_ff @(posedge clock) begin
      if (ctrl.scale_en) begin
         x_ff <= x_in;
      end
      if (ctrl.filt_en) begin
         p_ff <= p_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_ff <= '0;
      end else if (ctrl.round_en && !ctrl.bypass) begin
         y_ff <= y_in;
      end
   end

`ifndef SYNTHESIS
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.scale_en, ctrl.filt_en, ctrl.round_en}))
      else $error("lane steps overlap");
   a_bus_keeps_state: assert property (@(posedge clock) disable iff (reset)
      ctrl.round_en && ctrl.bypass |=> $stable(y_ff))
      else $error("bus beat changed filter state");
   a_state_tracks_out: assert property (@(posedge clock) disable iff (reset)
      ctrl.round_en && !ctrl.bypass |=> (y_ff == $past(value)))
      else $error("filter state differs from emitted value");
`endif

endmodule
